### sv/tdmb_pkg.sv
// ----------------------------------------------------------------------------
// tdmb_pkg
// Shared types, constants and functions of the tick divider with Morse beeper.
// ----------------------------------------------------------------------------
`default_nettype none

package tdmb_pkg;

    localparam int unsigned MSG_LEN     = 4;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned ELEM_W      = 3;
    localparam int unsigned PAT_W       = 5;
    localparam int unsigned ADDR_W      = 5;
    localparam int unsigned DATA_W      = 32;

    typedef enum logic [1:0] {
        MODE_STEADY = 2'd0,
        MODE_SILENT = 2'd1,
        MODE_BEACON = 2'd2,
        MODE_CHIRP  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_MSG_CHAR_0   = 3'd0,
        REG_MSG_CHAR_1   = 3'd1,
        REG_MSG_CHAR_2   = 3'd2,
        REG_MSG_CHAR_3   = 3'd3,
        REG_SERVO_DIVIDE = 3'd4,
        REG_SAFE_PERIOD  = 3'd5,
        REG_FLIGHT_PERIOD = 3'd6
    } t_reg_idx;

    localparam logic [CHAR_W-1:0] RST_MSG_CHAR_0    = 8'd49;
    localparam logic [CHAR_W-1:0] RST_MSG_CHAR_1    = 8'd53;
    localparam logic [CHAR_W-1:0] RST_MSG_CHAR_2    = 8'd48;
    localparam logic [CHAR_W-1:0] RST_MSG_CHAR_3    = 8'd55;
    localparam logic [CNT_W-1:0]  RST_SERVO_DIVIDE  = 8'd3;
    localparam logic [CNT_W-1:0]  RST_SAFE_PERIOD   = 8'd25;
    localparam logic [CNT_W-1:0]  RST_FLIGHT_PERIOD = 8'd125;

    localparam logic [CNT_W-1:0]  TONE_DAH     = 8'd20;
    localparam logic [CNT_W-1:0]  TONE_DIT     = 8'd6;
    localparam logic [CNT_W-1:0]  GAP_ELEMENT  = 8'd6;
    localparam logic [CNT_W-1:0]  GAP_CHAR     = 8'd50;
    localparam logic [CNT_W-1:0]  GAP_MESSAGE  = 8'd250;
    localparam logic [ELEM_W-1:0] ELEMS_AFTER_FIRST = 3'd4;

    localparam logic [CNT_W-1:0]  CHIRP_LOW_END  = 8'd10;
    localparam logic [CNT_W-1:0]  CHIRP_BAND_LO  = 8'd20;
    localparam logic [CNT_W-1:0]  CHIRP_BAND_HI  = 8'd40;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;

    typedef struct packed {
        logic [MSG_LEN-1:0][CHAR_W-1:0] msg_char;
        logic [CNT_W-1:0]               servo_divide;
        logic [CNT_W-1:0]               safe_period;
        logic [CNT_W-1:0]               flight_period;
    } t_cfg;

    typedef struct packed {
        logic measure_pulse;
        logic servo_pulse;
        logic buzzer_on;
    } t_result;

    typedef struct packed {
        logic             is_digit;
        logic [PAT_W-1:0] pattern;
    } t_digit;

    function automatic logic [CHAR_W-1:0] char_at(input t_cfg cfg,
                                                   input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        c = '0;
        if (idx < IDX_W'(MSG_LEN)) begin
            c = cfg.msg_char[idx[1:0]];
        end
        return c;
    endfunction

    function automatic t_digit digit_code(input logic [CHAR_W-1:0] c);
        t_digit           r;
        logic [CHAR_W-1:0] d;
        r.is_digit = 1'b0;
        r.pattern  = '0;
        d          = c - ASCII_ZERO;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            r.is_digit = 1'b1;
            case (d[3:0])
                4'd0: r.pattern = 5'b11111;
                4'd1: r.pattern = 5'b11110;
                4'd2: r.pattern = 5'b11100;
                4'd3: r.pattern = 5'b11000;
                4'd4: r.pattern = 5'b10000;
                4'd5: r.pattern = 5'b00000;
                4'd6: r.pattern = 5'b00001;
                4'd7: r.pattern = 5'b00011;
                4'd8: r.pattern = 5'b00111;
                4'd9: r.pattern = 5'b01111;
                default: r.pattern = 5'b00000;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/tdmb_cfg.sv
// ----------------------------------------------------------------------------
// tdmb_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module tdmb_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tdmb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tdmb_pkg::DATA_W-1:0] pwdata,
    output logic      [tdmb_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output tdmb_pkg::t_cfg                   o_cfg
);

    tdmb_pkg::t_cfg r_cfg;
    logic [2:0]     idx;
    logic           wr_en;
    logic [7:0]     rd_byte;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.msg_char[0]   <= tdmb_pkg::RST_MSG_CHAR_0;
            r_cfg.msg_char[1]   <= tdmb_pkg::RST_MSG_CHAR_1;
            r_cfg.msg_char[2]   <= tdmb_pkg::RST_MSG_CHAR_2;
            r_cfg.msg_char[3]   <= tdmb_pkg::RST_MSG_CHAR_3;
            r_cfg.servo_divide  <= tdmb_pkg::RST_SERVO_DIVIDE;
            r_cfg.safe_period   <= tdmb_pkg::RST_SAFE_PERIOD;
            r_cfg.flight_period <= tdmb_pkg::RST_FLIGHT_PERIOD;
        end else if (wr_en) begin
            case (idx)
                tdmb_pkg::REG_MSG_CHAR_0:    r_cfg.msg_char[0]   <= pwdata[7:0];
                tdmb_pkg::REG_MSG_CHAR_1:    r_cfg.msg_char[1]   <= pwdata[7:0];
                tdmb_pkg::REG_MSG_CHAR_2:    r_cfg.msg_char[2]   <= pwdata[7:0];
                tdmb_pkg::REG_MSG_CHAR_3:    r_cfg.msg_char[3]   <= pwdata[7:0];
                tdmb_pkg::REG_SERVO_DIVIDE:  r_cfg.servo_divide  <= pwdata[7:0];
                tdmb_pkg::REG_SAFE_PERIOD:   r_cfg.safe_period   <= pwdata[7:0];
                tdmb_pkg::REG_FLIGHT_PERIOD: r_cfg.flight_period <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            tdmb_pkg::REG_MSG_CHAR_0:    rd_byte = r_cfg.msg_char[0];
            tdmb_pkg::REG_MSG_CHAR_1:    rd_byte = r_cfg.msg_char[1];
            tdmb_pkg::REG_MSG_CHAR_2:    rd_byte = r_cfg.msg_char[2];
            tdmb_pkg::REG_MSG_CHAR_3:    rd_byte = r_cfg.msg_char[3];
            tdmb_pkg::REG_SERVO_DIVIDE:  rd_byte = r_cfg.servo_divide;
            tdmb_pkg::REG_SAFE_PERIOD:   rd_byte = r_cfg.safe_period;
            tdmb_pkg::REG_FLIGHT_PERIOD: rd_byte = r_cfg.flight_period;
            default:                     rd_byte = '0;
        endcase
        prdata = {{(tdmb_pkg::DATA_W-8){1'b0}}, rd_byte};
    end

endmodule

`default_nettype wire

### sv/tdmb_core.sv
// ----------------------------------------------------------------------------
// tdmb_core
// Tick counters, beacon sequencer and buzzer selection for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module tdmb_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [1:0] i_mode,
    input  wire logic       i_safe,
    input  wire tdmb_pkg::t_cfg i_cfg,
    output tdmb_pkg::t_result o_result
);

    logic [tdmb_pkg::CNT_W-1:0]  r_servo_count,   n_servo_count;
    logic [tdmb_pkg::CNT_W-1:0]  r_measure_count, n_measure_count;
    logic [tdmb_pkg::IDX_W-1:0]  r_char_index,    n_char_index;
    logic [tdmb_pkg::ELEM_W-1:0] r_elements_left, n_elements_left;
    logic [tdmb_pkg::CNT_W-1:0]  r_phase_timer,   n_phase_timer;
    logic [tdmb_pkg::PAT_W-1:0]  r_symbol_pattern, n_symbol_pattern;
    logic                        r_tone_phase,    n_tone_phase;

    logic [tdmb_pkg::CNT_W-1:0]  period;
    logic [tdmb_pkg::CHAR_W-1:0] cur_char;
    logic [tdmb_pkg::PAT_W-1:0]  shifted;
    tdmb_pkg::t_digit            digit;
    tdmb_pkg::t_result           res;

    assign cur_char = tdmb_pkg::char_at(i_cfg, r_char_index);
    assign digit    = tdmb_pkg::digit_code(cur_char);
    assign shifted  = {1'b0, r_symbol_pattern[tdmb_pkg::PAT_W-1:1]};
    assign period   = i_safe ? i_cfg.safe_period : i_cfg.flight_period;
    assign o_result = res;

    always_comb begin
        res.servo_pulse   = 1'b0;
        res.measure_pulse = 1'b0;
        res.buzzer_on     = 1'b0;

        n_servo_count = r_servo_count + 8'd1;
        if (n_servo_count >= i_cfg.servo_divide) begin
            n_servo_count   = '0;
            res.servo_pulse = 1'b1;
        end
        n_measure_count = r_measure_count + 8'd1;
        if (n_measure_count >= period) begin
            n_measure_count   = '0;
            res.measure_pulse = 1'b1;
        end

        n_char_index     = r_char_index;
        n_elements_left  = r_elements_left;
        n_phase_timer    = r_phase_timer;
        n_symbol_pattern = r_symbol_pattern;
        n_tone_phase     = r_tone_phase;

        if (i_mode == tdmb_pkg::MODE_BEACON) begin
            if (r_phase_timer != '0) begin
                n_phase_timer = r_phase_timer - 8'd1;
            end else if (r_tone_phase) begin
                n_tone_phase  = 1'b0;
                n_phase_timer = (r_elements_left == '0) ? tdmb_pkg::GAP_CHAR
                                                        : tdmb_pkg::GAP_ELEMENT;
                if (r_elements_left == '0 && cur_char == '0) begin
                    n_char_index  = '0;
                    n_phase_timer = tdmb_pkg::GAP_MESSAGE;
                end
            end else if (r_elements_left != '0) begin
                n_elements_left  = r_elements_left - 3'd1;
                n_symbol_pattern = shifted;
                n_phase_timer    = shifted[0] ? tdmb_pkg::TONE_DAH : tdmb_pkg::TONE_DIT;
                n_tone_phase     = 1'b1;
            end else begin
                if (digit.is_digit) begin
                    n_symbol_pattern = digit.pattern;
                    n_elements_left  = tdmb_pkg::ELEMS_AFTER_FIRST;
                    n_tone_phase     = 1'b1;
                    n_phase_timer    = digit.pattern[0] ? tdmb_pkg::TONE_DAH
                                                        : tdmb_pkg::TONE_DIT;
                end else begin
                    n_symbol_pattern = '0;
                end
                n_char_index = (r_char_index >= tdmb_pkg::IDX_W'(tdmb_pkg::MSG_LEN))
                             ? '0 : r_char_index + 3'd1;
            end
        end

        case (i_mode)
            tdmb_pkg::MODE_STEADY: res.buzzer_on = 1'b1;
            tdmb_pkg::MODE_SILENT: res.buzzer_on = 1'b0;
            tdmb_pkg::MODE_BEACON: res.buzzer_on = n_tone_phase;
            default: begin
                res.buzzer_on = (n_measure_count < tdmb_pkg::CHIRP_LOW_END)
                             || (n_measure_count > tdmb_pkg::CHIRP_BAND_LO
                                 && n_measure_count < tdmb_pkg::CHIRP_BAND_HI);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servo_count    <= '0;
            r_measure_count  <= '0;
            r_char_index     <= '0;
            r_elements_left  <= '0;
            r_phase_timer    <= '0;
            r_symbol_pattern <= '0;
            r_tone_phase     <= 1'b0;
        end else if (i_advance) begin
            r_servo_count    <= n_servo_count;
            r_measure_count  <= n_measure_count;
            r_char_index     <= n_char_index;
            r_elements_left  <= n_elements_left;
            r_phase_timer    <= n_phase_timer;
            r_symbol_pattern <= n_symbol_pattern;
            r_tone_phase     <= n_tone_phase;
        end
    end

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_index <= 3'd4)
        else $error("Message index beyond the terminator.");

    a_elements_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elements_left <= tdmb_pkg::ELEMS_AFTER_FIRST)
        else $error("Element count out of range.");

    a_beacon_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_mode != tdmb_pkg::MODE_BEACON) |=>
        ($stable(r_phase_timer) && $stable(r_tone_phase) && $stable(r_char_index)))
        else $error("Beacon state moved outside beacon mode.");

    a_servo_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && res.servo_pulse) |=> (r_servo_count == '0))
        else $error("Servo counter did not clear on its pulse.");

    a_silent_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_mode == tdmb_pkg::MODE_BEACON && r_phase_timer == '0
         && r_tone_phase) |=> !r_tone_phase)
        else $error("Tone did not end when its timer ran out.");

endmodule

`default_nettype wire

### sv/tick_divider_morse_beeper.sv
// ----------------------------------------------------------------------------
// tick_divider_morse_beeper
// Timer tick divider with servo and measure pulses and a Morse beacon buzzer.
// ----------------------------------------------------------------------------
// A tick is held in the input register and then in the result register.
// Throughput: one tick per cycle while the result is taken, set by the single
// input and result register; a result that waits to be taken stalls the input.
// Reset is synchronous and active low; it clears counters, beacon state and
// valid flags, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_divider_morse_beeper (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // [1:0] buzzer_mode, [2] safe_mode, [7:3] zero
    input  wire logic [7:0]                  s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [0] buzzer_on, [1] servo_pulse, [2] measure_pulse, [7:3] zero
    output logic      [7:0]                  m_tdata,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tdmb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tdmb_pkg::DATA_W-1:0] pwdata,
    output logic      [tdmb_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    tdmb_pkg::t_cfg    cfg;
    tdmb_pkg::t_result result;

    logic       r_in_valid;
    logic [1:0] r_in_mode;
    logic       r_in_safe;
    logic       r_out_valid;
    logic [2:0] r_out_data;
    logic       advance;

    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'd0, r_out_data};

    tdmb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tdmb_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_mode    (r_in_mode),
        .i_safe    (r_in_safe),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_mode <= s_tdata[1:0];
            r_in_safe <= s_tdata[2];
        end
        if (advance) begin
            r_out_data <= {result.measure_pulse, result.servo_pulse, result.buzzer_on};
        end
    end

endmodule

`default_nettype wire
